FILE: sv/hbm_pkg.sv
package hbm_pkg;

	localparam int BUCKETS = 1024;   // power of two: bucket = low key bits
	localparam int WAYS    = 4;
	localparam int ENTRIES = BUCKETS * WAYS;

	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int ENT_W  = $clog2(ENTRIES);
	localparam int FILL_W = $clog2(WAYS + 1);

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FILL,
		S_RD,
		S_CMP,
		S_SH_RD,
		S_SH_WR,
		S_WB,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [BKT_W-1:0]  waddr;
		logic [FILL_W-1:0] wdata;
		logic [BKT_W-1:0]  raddr;
	} fill_req_t;

	typedef struct packed {
		logic             we;
		logic [ENT_W-1:0] waddr;
		entry_t           wdata;
		logic [ENT_W-1:0] raddr;
	} entry_req_t;

endpackage

FILE: sv/hbm_ram.sv
module hbm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/hbm_seq.sv
module hbm_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [hbm_pkg::CMD_W-1:0]  in_cmd,
	input  logic [hbm_pkg::KEY_W-1:0]  in_key,
	input  logic [hbm_pkg::VAL_W-1:0]  in_value,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output hbm_pkg::status_t           out_status,
	output logic [hbm_pkg::VAL_W-1:0]  out_value,
	output hbm_pkg::fill_req_t         fill_req,
	input  logic [hbm_pkg::FILL_W-1:0] fill_rdata,
	output hbm_pkg::entry_req_t        ent_req,
	input  hbm_pkg::entry_t            ent_rdata
);

	import hbm_pkg::*;

	seq_state_t        state_q, state_d;
	logic [BKT_W-1:0]  clr_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [BKT_W-1:0]  bkt_q;
	logic [ENT_W-1:0]  base_q;
	logic [FILL_W-1:0] n_q;
	logic [FILL_W-1:0] i_q;
	status_t           st_q;
	logic [VAL_W-1:0]  rv_q;
	logic              m_tvalid_q;
	status_t           m_status_q;
	logic [VAL_W-1:0]  m_value_q;

	logic [BKT_W-1:0]  bucket_in;
	logic              key_hit;
	logic [FILL_W-1:0] i_nx;
	logic [FILL_W-1:0] i_nx2;
	logic [FILL_W-1:0] slot_sel;
	logic [ENT_W-1:0]  ent_addr;
	logic              fill_full;
	logic              out_free;

	assign bucket_in = in_key[BKT_W-1:0];
	assign key_hit   = (ent_rdata.key == key_q);
	assign i_nx      = i_q + FILL_W'(1);
	assign i_nx2     = i_q + FILL_W'(2);
	assign slot_sel  = (state_q == S_SH_RD) ? i_nx : i_q;
	assign ent_addr  = base_q + ENT_W'(slot_sel);
	assign fill_full = (fill_rdata >= FILL_W'(WAYS));
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		state_d        = state_q;
		s_tready       = 1'b0;
		fill_req.we    = 1'b0;
		fill_req.waddr = bkt_q;
		fill_req.wdata = '0;
		fill_req.raddr = (state_q == S_IDLE) ? bucket_in : bkt_q;
		ent_req.we     = 1'b0;
		ent_req.waddr  = ent_addr;
		ent_req.wdata  = ent_rdata;
		ent_req.raddr  = ent_addr;
		case (state_q)
			S_CLEAR: begin
				fill_req.we    = 1'b1;
				fill_req.waddr = clr_q;
				if (clr_q == BKT_W'(BUCKETS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				case (cmd_q)
					CMD_INSERT: begin
						if (!fill_full) begin
							// append at the slot past the last valid entry
							ent_req.we          = 1'b1;
							ent_req.waddr       = base_q + ENT_W'(fill_rdata);
							ent_req.wdata.key   = key_q;
							ent_req.wdata.value = val_q;
							fill_req.we         = 1'b1;
							fill_req.wdata      = fill_rdata + FILL_W'(1);
						end
						state_d = S_DONE;
					end
					CMD_LOOKUP, CMD_DELETE: begin
						state_d = (fill_rdata == '0) ? S_DONE : S_RD;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_RD: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (key_hit) begin
					if (cmd_q == CMD_DELETE) begin
						state_d = (i_nx < n_q) ? S_SH_RD : S_WB;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					state_d = (i_nx < n_q) ? S_RD : S_DONE;
				end
			end
			S_SH_RD: begin
				state_d = S_SH_WR;
			end
			S_SH_WR: begin
				// move the younger entry down one slot
				ent_req.we = 1'b1;
				state_d    = (i_nx2 < n_q) ? S_SH_RD : S_WB;
			end
			S_WB: begin
				fill_req.we    = 1'b1;
				fill_req.wdata = n_q - FILL_W'(1);
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + BKT_W'(1);
			end
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd_q  <= in_cmd;
					key_q  <= in_key;
					val_q  <= in_value;
					bkt_q  <= bucket_in;
					base_q <= ENT_W'(bucket_in) * ENT_W'(WAYS);
					st_q   <= STAT_NOT_FOUND;
					rv_q   <= '0;
				end
			end
			S_FILL: begin
				n_q <= fill_rdata;
				i_q <= '0;
				if (cmd_q == CMD_INSERT) begin
					st_q <= fill_full ? STAT_FULL : STAT_OK;
				end
			end
			S_CMP: begin
				if (key_hit) begin
					st_q <= STAT_OK;
					rv_q <= ent_rdata.value;
				end else begin
					i_q <= i_nx;
				end
			end
			S_SH_WR: begin
				i_q <= i_nx;
			end
			S_DONE: begin
				if (out_free) begin
					m_status_q <= st_q;
					m_value_q  <= rv_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid   = m_tvalid_q;
	assign out_status = m_status_q;
	assign out_value  = m_value_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_CMP) |-> (i_q < n_q))
		else $error("slot scan past bucket fill");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_req.we |-> (fill_req.wdata <= FILL_W'(WAYS)))
		else $error("bucket fill written above way count");

	a_wb_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB) |-> (n_q != '0 && cmd_q == CMD_DELETE && st_q == STAT_OK))
		else $error("fill decrement without a removed entry");

	a_full_insert_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && st_q == STAT_FULL) |-> (cmd_q == CMD_INSERT))
		else $error("full status on a non-insert request");

	a_accept_to_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_FILL))
		else $error("accepted request did not start a bucket read");

endmodule

FILE: sv/bucketed_hash_map.sv
// channel | dir | tdata (low bit up)            | tuser
// s_*     | in  | key[31:0], value[63:32]       | cmd (0 lookup, 1 insert, 2 delete)
// m_*     | out | result_value[31:0]            | status (0 ok, 1 not found, 2 full)
//
// One request at a time: read bucket fill; insert appends at the next free slot, while
// lookup and delete compare the key one slot at a time through the entry RAM; delete
// then shifts each younger entry down one slot and writes the fill back.
// After reset a clearing pass zeroes every bucket of the fill RAM with s_tready low.
// A finished result sits in the output register; a stalled m_tready holds the next
// result in the sequencer and keeps s_tready low until the register frees up.
module bucketed_hash_map (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [63:0]                 s_tdata,   // key, value
	input  logic [hbm_pkg::CMD_W-1:0]   s_tuser,   // cmd
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,   // result_value
	output logic [hbm_pkg::STAT_W-1:0]  m_tuser    // status
);

	import hbm_pkg::*;

	fill_req_t         fill_req;
	entry_req_t        ent_req;
	logic [FILL_W-1:0] fill_rdata;
	entry_t            ent_rdata;
	status_t           out_status;
	logic [VAL_W-1:0]  out_value;

	hbm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.in_cmd     (s_tuser),
		.in_key     (s_tdata[KEY_W-1:0]),
		.in_value   (s_tdata[KEY_W+VAL_W-1:KEY_W]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_status (out_status),
		.out_value  (out_value),
		.fill_req   (fill_req),
		.fill_rdata (fill_rdata),
		.ent_req    (ent_req),
		.ent_rdata  (ent_rdata)
	);

	hbm_ram #(
		.WIDTH (FILL_W),
		.DEPTH (BUCKETS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_req.we),
		.waddr (fill_req.waddr),
		.wdata (fill_req.wdata),
		.raddr (fill_req.raddr),
		.rdata (fill_rdata)
	);

	hbm_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_req.we),
		.waddr (ent_req.waddr),
		.wdata (ent_req.wdata),
		.raddr (ent_req.raddr),
		.rdata (ent_rdata)
	);

	assign m_tdata = out_value;
	assign m_tuser = out_status;

endmodule

FILE: bench/hbm_checker.sv
module hbm_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [63:0]                 s_tdata,   // key, value
	input  logic [hbm_pkg::CMD_W-1:0]   s_tuser,   // cmd
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [31:0]                 m_tdata,   // result_value
	input  logic [hbm_pkg::STAT_W-1:0]  m_tuser,   // status
	output int                          mismatches,
	output int                          outstanding,
	output int                          n_ok,
	output int                          n_missing,
	output int                          n_full
);

	import hbm_pkg::*;

	typedef struct packed {
		status_t           status;
		logic [VAL_W-1:0]  value;
	} map_result_t;

	logic [KEY_W-1:0] slot_key [BUCKETS][WAYS];
	logic [VAL_W-1:0] slot_val [BUCKETS][WAYS];
	int unsigned      fill_count [BUCKETS];

	map_result_t expected_results [$];
	map_result_t head;

	int err_cnt;
	int ok_cnt;
	int missing_cnt;
	int full_cnt;

	assign mismatches = err_cnt;
	assign n_ok       = ok_cnt;
	assign n_missing  = missing_cnt;
	assign n_full     = full_cnt;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_cnt++;
		if (err_cnt <= 40)
			$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	// Apply one request to the mirrored table and return its expected result.
	function automatic map_result_t apply_request(input logic [CMD_W-1:0] cmd,
			input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val);
		int          bkt;
		int          n;
		int          hit;
		map_result_t r;
		bkt = key[BKT_W-1:0];
		n   = fill_count[bkt];
		hit = -1;
		r.status = STAT_NOT_FOUND;
		r.value  = '0;
		for (int i = 0; i < n; i++) begin
			if (hit < 0 && slot_key[bkt][i] == key)
				hit = i;
		end
		case (cmd)
			CMD_LOOKUP: begin
				if (hit >= 0) begin
					r.status = STAT_OK;
					r.value  = slot_val[bkt][hit];
				end
			end
			CMD_INSERT: begin
				if (n >= WAYS) begin
					r.status = STAT_FULL;
				end else begin
					slot_key[bkt][n] = key;
					slot_val[bkt][n] = val;
					fill_count[bkt]  = n + 1;
					r.status = STAT_OK;
				end
			end
			CMD_DELETE: begin
				if (hit >= 0) begin
					r.status = STAT_OK;
					r.value  = slot_val[bkt][hit];
					// close the gap: younger entries move down one slot
					for (int i = hit; i + 1 < n; i++) begin
						slot_key[bkt][i] = slot_key[bkt][i+1];
						slot_val[bkt][i] = slot_val[bkt][i+1];
					end
					fill_count[bkt] = n - 1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BUCKETS; b++)
				fill_count[b] = 0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			// results can only belong to earlier requests, so check before predicting
			if (m_tvalid && m_tready) begin
				case (m_tuser)
					STAT_OK:        ok_cnt++;
					STAT_NOT_FOUND: missing_cnt++;
					default:        full_cnt++;
				endcase
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request pending", {30'b0, m_tuser}, '0);
				end else begin
					head = expected_results.pop_front();
					if (m_tuser !== head.status)
						report_mismatch("status", {30'b0, m_tuser}, {30'b0, head.status});
					if (m_tdata !== head.value)
						report_mismatch("result_value", m_tdata, head.value);
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_request(s_tuser, s_tdata[31:0],
					s_tdata[63:32]));
			outstanding <= expected_results.size();
		end
	end

endmodule

FILE: bench/tb.sv
module tb;

	import hbm_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int POOL_BUCKETS = 6;
	localparam int KEYS_PER_BKT = 5;
	localparam int POOL_SIZE    = POOL_BUCKETS * KEYS_PER_BKT;
	localparam int RANDOM_ITEMS = 1930;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [63:0]        s_tdata;
	logic [CMD_W-1:0]   s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [31:0]        m_tdata;
	logic [STAT_W-1:0]  m_tuser;

	int mismatches;
	int outstanding;
	int n_ok;
	int n_missing;
	int n_full;

	int hold_reqs;
	int hold_cnt;
	int burst_left;

	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	bucketed_hash_map uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	hbm_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.n_ok        (n_ok),
		.n_missing   (n_missing),
		.n_full      (n_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random stall modes, plus one long hold-off on request.
	initial begin
		int  mode;
		int  mode_left;
		int  hold_done;
		bit  rdy;
		mode      = 0;
		mode_left = 0;
		hold_done = 0;
		hold_cnt  = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cnt > 0) begin
				hold_cnt--;
				rdy = 1'b0;
			end else if (hold_reqs != hold_done) begin
				hold_done++;
				hold_cnt = 299;
				rdy = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				case (mode)
					0:       rdy = 1'b1;
					1:       rdy = ($urandom_range(0, 1) == 0);
					default: rdy = ($urandom_range(0, 3) == 0);
				endcase
			end
			m_tready <= rdy;
		end
	end

	// Offer one request and hold it until accepted; idle between bursts.
	task automatic send(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {val, key};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		logic [CMD_W-1:0] c;
		int               bkt;
		int               r;
		arst_n     = 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_LOOKUP;
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty bucket, fill it with a duplicate, overflow, then unwind
		send(CMD_LOOKUP, 32'h0000_0000, 32'h0);
		send(CMD_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
		send(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
		send(CMD_INSERT, 32'hFFFF_FC00, 32'h0000_0000);
		send(CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
		send(CMD_INSERT, 32'h0000_0400, 32'hA5A5_A5A5);
		send(CMD_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);
		send(CMD_LOOKUP, 32'h0000_0000, 32'h0);
		send(CMD_LOOKUP, 32'h8000_0000, 32'h0);
		send(CMD_DELETE, 32'hFFFF_FC00, 32'h0);
		send(CMD_LOOKUP, 32'h0000_0400, 32'h0);
		send(CMD_DELETE, 32'h0000_0000, 32'h0);
		send(CMD_LOOKUP, 32'h0000_0000, 32'h0);
		send(CMD_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
		send(CMD_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
		send(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0);
		send(CMD_DELETE, 32'hFFFF_FFFF, 32'h0);
		send(CMD_DELETE, 32'hFFFF_FFFF, 32'h0);
		send(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain_results();

		// crowd a few buckets, edge buckets among them, so that full and shifts recur
		for (int b = 0; b < POOL_BUCKETS; b++) begin
			bkt = (b == 0) ? 0 : (b == 1) ? BUCKETS - 1 : $urandom_range(1, BUCKETS - 2);
			for (int j = 0; j < KEYS_PER_BKT; j++) begin
				k = $urandom();
				k[BKT_W-1:0] = bkt[BKT_W-1:0];
				key_pool[b * KEYS_PER_BKT + j] = k;
			end
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35)      c = CMD_INSERT;
			else if (r < 65) c = CMD_DELETE;
			else if (r < 97) c = CMD_LOOKUP;
			else             c = CMD_UNUSED;
			if ($urandom_range(0, 99) < 8)
				k = $urandom();
			else
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			r = $urandom_range(0, 15);
			v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
			send(c, k, v);
			if (i == 600)
				hold_reqs++;
			if (i == 1200)
				drain_results();
		end

		drain_results();
		repeat (50) @(posedge clk);

		$display("Ran %0d requests on crowded buckets and random keys: %0d ok, %0d not found, %0d full",
			n_ok + n_missing + n_full, n_ok, n_missing, n_full);
		$display("Output held off for 300 cycles once; input drained to idle twice mid-run");
		if (mismatches == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
